### hdl/hsts_pkg.sv
// Shared constants, types and constant tables of the harmonic sine tone synthesizer.
package hsts_pkg;

   // Datapath sizing
   localparam int TIME_BITS      = 24;
   localparam int PHASE_BITS     = 32;
   localparam int SINE_ADDR_BITS = 10;
   localparam int QUAD_BITS      = SINE_ADDR_BITS - 2;
   localparam int QUAD_SIZE      = 1 << QUAD_BITS;
   localparam int SINE_BITS      = 15;
   localparam int HARMONICS      = 3;
   localparam int STAGES         = 10;

   // CSR port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_BASE_STEP  = 2'd0,
      REG_TONE_MODE  = 2'd1,
      REG_WIDE       = 2'd2,
      REG_RIGHT_ATT  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_PURE   = 2'd0,
      MODE_FUND   = 2'd1,
      MODE_SECOND = 2'd2,
      MODE_THIRD  = 2'd3
   } tone_mode_type;

   // Register reset values
   localparam logic [31:0] BASE_STEP_RESET  = 32'd118111601;
   localparam logic [1:0]  TONE_MODE_RESET  = 2'd0;
   localparam logic        WIDE_RESET       = 1'b1;
   localparam logic        RIGHT_ATT_RESET  = 1'b0;

   // Harmonic gains, Q15
   localparam logic signed [16:0] GAIN_UNITY  = 17'sd32768;
   localparam logic signed [16:0] GAIN_FUND   = 17'sd19661;
   localparam logic signed [16:0] GAIN_SECOND = 17'sd6554;
   localparam logic signed [16:0] GAIN_THIRD  = 17'sd3277;
   localparam logic signed [16:0] GAIN_NONE   = 17'sd0;

   // Output PCM gains
   localparam logic signed [15:0] PCM16_GAIN     = 16'sd30000;
   localparam logic signed [15:0] PCM16_GAIN_ATT = 16'sd20003;
   localparam logic signed [15:0] PCM8_GAIN      = 16'sd100;
   localparam logic signed [15:0] PCM8_GAIN_ATT  = 16'sd20;

   localparam logic [15:0] SILENCE_WIDE   = 16'h0000;
   localparam logic [15:0] SILENCE_NARROW = 16'h0080;

   // Semitone ratio 2^(k/12) in Q16
   function automatic logic [16:0] ratio_q16(input logic [3:0] k);
      logic [16:0] r;
      unique case (k)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd69433;
         4'd2:    r = 17'd73562;
         4'd3:    r = 17'd77936;
         4'd4:    r = 17'd82570;
         4'd5:    r = 17'd87480;
         4'd6:    r = 17'd92682;
         4'd7:    r = 17'd98193;
         4'd8:    r = 17'd104032;
         4'd9:    r = 17'd110218;
         4'd10:   r = 17'd116772;
         4'd11:   r = 17'd123715;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

   // Quarter-wave polynomial sine, Q15, evaluated at elaboration only
   function automatic logic [SINE_BITS-1:0] sine_point(input int unsigned idx);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned inner;
      longint unsigned mid;
      longint unsigned s;
      x     = longint'(idx) << (15 - QUAD_BITS);
      x2    = (x * x) >> 15;
      inner = 64'd21167 - ((64'd2611 * x2) >> 15);
      mid   = 64'd51472 - ((x2 * inner) >> 15);
      s     = (x * mid) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return SINE_BITS'(s);
   endfunction

   typedef logic [QUAD_SIZE-1:0][SINE_BITS-1:0] sine_rom_type;

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int i = 0; i < QUAD_SIZE; i++) begin
         rom[i] = sine_point(i);
      end
      return rom;
   endfunction

   localparam sine_rom_type        SINE_ROM  = build_sine_rom();
   localparam logic [SINE_BITS-1:0] SINE_PEAK = sine_point(QUAD_SIZE);

endpackage

### hdl/harmonic_sine_tone_synth_unit.sv
// Top level of the harmonic sine tone synthesizer: CSRs and the ten-stage datapath.
//
//  channel | ports          | beat contents
//  --------+----------------+-----------------------------------------
//  req     | valid / stall  | sample_time, semitone, is_rest
//  rsp     | valid / stall  | left_sample, right_sample
//  csr     | APB            | base_phase_step, tone_mode, wide_samples, right_attenuate
//
//  One beat enters per cycle while req_stall is low; a result leaves after its beat has
//  passed the ten register stages (ratio lookup, step multiplier, step rounding, phase
//  multiplier, quarter-wave fold, sine ROM, gain multipliers, mix add, PCM multipliers,
//  rounding). A stalled result freezes the whole pipeline, so req_stall follows it.
//  Reset clears all stage valid bits and returns the CSRs to their defaults.
module harmonic_sine_tone_synth_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [hsts_pkg::TIME_BITS-1:0]       req_sample_time,
   input  logic signed [6:0]                    req_semitone,
   input  logic                                 req_is_rest,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [15:0]                          rsp_left_sample,
   output logic [15:0]                          rsp_right_sample,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [hsts_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [hsts_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [hsts_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int PB = hsts_pkg::PHASE_BITS;
   localparam int QB = hsts_pkg::QUAD_BITS;
   localparam int NH = hsts_pkg::HARMONICS;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [31:0] base_step_ff;
   logic [1:0]  tone_mode_ff;
   logic        wide_ff;
   logic        right_att_ff;
   logic        csr_write;
   hsts_pkg::csr_index_type csr_index;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = hsts_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_step_ff <= hsts_pkg::BASE_STEP_RESET;
         tone_mode_ff <= hsts_pkg::TONE_MODE_RESET;
         wide_ff      <= hsts_pkg::WIDE_RESET;
         right_att_ff <= hsts_pkg::RIGHT_ATT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            hsts_pkg::REG_BASE_STEP: base_step_ff <= csr_pwdata;
            hsts_pkg::REG_TONE_MODE: tone_mode_ff <= csr_pwdata[1:0];
            hsts_pkg::REG_WIDE:      wide_ff      <= csr_pwdata[0];
            hsts_pkg::REG_RIGHT_ATT: right_att_ff <= csr_pwdata[0];
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (csr_index)
         hsts_pkg::REG_BASE_STEP: csr_prdata = base_step_ff;
         hsts_pkg::REG_TONE_MODE: csr_prdata = {30'd0, tone_mode_ff};
         hsts_pkg::REG_WIDE:      csr_prdata = {31'd0, wide_ff};
         hsts_pkg::REG_RIGHT_ATT: csr_prdata = {31'd0, right_att_ff};
      endcase
   end

   // ---------------------------------------------------------------
   // Pipeline control: whole pipe holds while the result is stalled
   // ---------------------------------------------------------------
   logic                          advance;
   logic [hsts_pkg::STAGES-1:0]   valid_ff;
   logic [hsts_pkg::STAGES-1:0]   valid_in;

   assign advance   = !(valid_ff[hsts_pkg::STAGES-1] && rsp_stall);
   assign req_stall = !advance;
   assign valid_in  = {valid_ff[hsts_pkg::STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: semitone -> ratio and octave
   // ---------------------------------------------------------------
   logic [7:0]                      note_idx;
   logic [17:0]                     oct_prod;
   logic [3:0]                      oct_q;
   logic [7:0]                      oct_base;
   logic [16:0]                     s1_ratio_in;
   logic signed [3:0]               s1_oct_in;
   logic [16:0]                     s1_ratio_ff;
   logic signed [3:0]               s1_oct_ff;
   logic [hsts_pkg::TIME_BITS-1:0]  s1_time_ff;
   logic                            s1_rest_ff;

   always_comb begin
      // n = s + 72 lies in 8..135; n / 12 by reciprocal 683 / 2^13
      note_idx    = {req_semitone[6], req_semitone} + 8'd72;
      oct_prod    = 18'(note_idx) * 18'd683;
      oct_q       = oct_prod[16:13];
      oct_base    = {1'b0, oct_q, 3'b000} + {2'b00, oct_q, 2'b00};
      s1_ratio_in = hsts_pkg::ratio_q16(4'(note_idx - oct_base));
      s1_oct_in   = 4'(oct_q - 4'd6);
   end

   // ---------------------------------------------------------------
   // Stage 2: base step times ratio
   // ---------------------------------------------------------------
   logic [48:0]                     s2_prod_in;
   logic [48:0]                     s2_prod_ff;
   logic signed [3:0]               s2_oct_ff;
   logic [hsts_pkg::TIME_BITS-1:0]  s2_time_ff;
   logic                            s2_rest_ff;

   assign s2_prod_in = 49'(base_step_ff) * 49'(s1_ratio_ff);

   // ---------------------------------------------------------------
   // Stage 3: round to step, octave shift
   // ---------------------------------------------------------------
   logic [48:0]                     step_round;
   logic [32:0]                     step_full;
   logic [2:0]                      shift_right;
   logic [31:0]                     s3_step_in;
   logic [31:0]                     s3_step_ff;
   logic [hsts_pkg::TIME_BITS-1:0]  s3_time_ff;
   logic                            s3_rest_ff;

   always_comb begin
      step_round  = s2_prod_ff + 49'd32768;
      step_full   = step_round[48:16];
      shift_right = 3'(-s2_oct_ff);
      if (s2_oct_ff[3]) begin
         s3_step_in = 32'(step_full >> shift_right);
      end else begin
         s3_step_in = 32'(step_full << s2_oct_ff[2:0]);
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: phase = time * step, modulo 2^32
   // ---------------------------------------------------------------
   logic [hsts_pkg::TIME_BITS+31:0] phase_prod;
   logic [PB-1:0]                   s4_phase_in;
   logic [PB-1:0]                   s4_phase_ff;
   logic                            s4_rest_ff;

   always_comb begin
      phase_prod  = (hsts_pkg::TIME_BITS+32)'(s3_time_ff) *
                    (hsts_pkg::TIME_BITS+32)'(s3_step_ff);
      s4_phase_in = phase_prod[31 -: PB];
   end

   // ---------------------------------------------------------------
   // Stage 5: harmonic addresses, quarter-wave fold
   // ---------------------------------------------------------------
   logic [PB-1:0]                        hphase [NH];
   logic [hsts_pkg::SINE_ADDR_BITS-1:0]  haddr  [NH];
   logic [QB:0]                          s5_idx_in [NH];
   logic                                 s5_neg_in [NH];
   logic [QB:0]                          s5_idx_ff [NH];
   logic                                 s5_neg_ff [NH];
   logic                                 s5_rest_ff;

   always_comb begin
      hphase[0] = s4_phase_ff;
      hphase[1] = s4_phase_ff << 1;
      hphase[2] = s4_phase_ff + (s4_phase_ff << 1);
      for (int h = 0; h < NH; h++) begin
         haddr[h]     = hphase[h][PB-1 -: hsts_pkg::SINE_ADDR_BITS];
         s5_neg_in[h] = haddr[h][QB+1];
         if (haddr[h][QB]) begin
            s5_idx_in[h] = (QB+1)'(hsts_pkg::QUAD_SIZE) - {1'b0, haddr[h][QB-1:0]};
         end else begin
            s5_idx_in[h] = {1'b0, haddr[h][QB-1:0]};
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: sine table lookup and sign
   // ---------------------------------------------------------------
   logic [hsts_pkg::SINE_BITS-1:0]  sine_mag   [NH];
   logic signed [15:0]              s6_sine_in [NH];
   logic signed [15:0]              s6_sine_ff [NH];
   logic                            s6_rest_ff;

   always_comb begin
      for (int h = 0; h < NH; h++) begin
         if (s5_idx_ff[h][QB]) begin
            sine_mag[h] = hsts_pkg::SINE_PEAK;
         end else begin
            sine_mag[h] = hsts_pkg::SINE_ROM[s5_idx_ff[h][QB-1:0]];
         end
         if (s5_neg_ff[h]) begin
            s6_sine_in[h] = -signed'({1'b0, sine_mag[h]});
         end else begin
            s6_sine_in[h] = signed'({1'b0, sine_mag[h]});
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 7: harmonic gains
   // ---------------------------------------------------------------
   logic signed [16:0]  hgain      [NH];
   logic signed [32:0]  s7_prod_in [NH];
   logic signed [32:0]  s7_prod_ff [NH];
   logic                s7_rest_ff;

   always_comb begin
      unique case (hsts_pkg::tone_mode_type'(tone_mode_ff))
         hsts_pkg::MODE_PURE: begin
            hgain[0] = hsts_pkg::GAIN_UNITY;
            hgain[1] = hsts_pkg::GAIN_NONE;
            hgain[2] = hsts_pkg::GAIN_NONE;
         end
         hsts_pkg::MODE_FUND: begin
            hgain[0] = hsts_pkg::GAIN_FUND;
            hgain[1] = hsts_pkg::GAIN_NONE;
            hgain[2] = hsts_pkg::GAIN_NONE;
         end
         hsts_pkg::MODE_SECOND: begin
            hgain[0] = hsts_pkg::GAIN_FUND;
            hgain[1] = hsts_pkg::GAIN_SECOND;
            hgain[2] = hsts_pkg::GAIN_NONE;
         end
         hsts_pkg::MODE_THIRD: begin
            hgain[0] = hsts_pkg::GAIN_FUND;
            hgain[1] = hsts_pkg::GAIN_SECOND;
            hgain[2] = hsts_pkg::GAIN_THIRD;
         end
      endcase
      for (int h = 0; h < NH; h++) begin
         s7_prod_in[h] = 33'(s6_sine_ff[h]) * 33'(hgain[h]);
      end
   end

   // ---------------------------------------------------------------
   // Stage 8: mix sum, Q30
   // ---------------------------------------------------------------
   logic signed [34:0]  mix_sum;
   logic signed [31:0]  s8_mix_in;
   logic signed [31:0]  s8_mix_ff;
   logic                s8_rest_ff;

   always_comb begin
      mix_sum   = 35'(s7_prod_ff[0]) + 35'(s7_prod_ff[1]) + 35'(s7_prod_ff[2]);
      s8_mix_in = 32'(mix_sum);
   end

   // ---------------------------------------------------------------
   // Stage 9: PCM gain for both channels
   // ---------------------------------------------------------------
   logic signed [15:0]  left_gain;
   logic signed [15:0]  right_gain;
   logic signed [47:0]  s9_left_in;
   logic signed [47:0]  s9_right_in;
   logic signed [47:0]  s9_left_ff;
   logic signed [47:0]  s9_right_ff;
   logic                s9_rest_ff;

   always_comb begin
      if (wide_ff) begin
         left_gain  = hsts_pkg::PCM16_GAIN;
         right_gain = right_att_ff ? hsts_pkg::PCM16_GAIN_ATT : hsts_pkg::PCM16_GAIN;
      end else begin
         left_gain  = hsts_pkg::PCM8_GAIN;
         right_gain = right_att_ff ? hsts_pkg::PCM8_GAIN_ATT : hsts_pkg::PCM8_GAIN;
      end
      s9_left_in  = 48'(s8_mix_ff) * 48'(left_gain);
      s9_right_in = 48'(s8_mix_ff) * 48'(right_gain);
   end

   // ---------------------------------------------------------------
   // Stage 10: round half up, encode PCM, result register
   // ---------------------------------------------------------------
   logic signed [47:0]  left_round;
   logic signed [47:0]  right_round;
   logic [15:0]         left_pcm;
   logic [15:0]         right_pcm;
   logic [15:0]         rsp_left_in;
   logic [15:0]         rsp_right_in;
   logic [15:0]         rsp_left_ff;
   logic [15:0]         rsp_right_ff;

   always_comb begin
      left_round  = s9_left_ff + 48'sd536870912;
      right_round = s9_right_ff + 48'sd536870912;
      left_pcm    = left_round[45:30];
      right_pcm   = right_round[45:30];
      if (s9_rest_ff) begin
         rsp_left_in  = wide_ff ? hsts_pkg::SILENCE_WIDE : hsts_pkg::SILENCE_NARROW;
         rsp_right_in = rsp_left_in;
      end else if (wide_ff) begin
         rsp_left_in  = left_pcm;
         rsp_right_in = right_pcm;
      end else begin
         // offset binary: add midscale to the low byte
         rsp_left_in  = {8'd0, ~left_pcm[7], left_pcm[6:0]};
         rsp_right_in = {8'd0, ~right_pcm[7], right_pcm[6:0]};
      end
   end

   // ---------------------------------------------------------------
   // Datapath registers, all held on stall
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ratio_ff  <= s1_ratio_in;
         s1_oct_ff    <= s1_oct_in;
         s1_time_ff   <= req_sample_time;
         s1_rest_ff   <= req_is_rest;

         s2_prod_ff   <= s2_prod_in;
         s2_oct_ff    <= s1_oct_ff;
         s2_time_ff   <= s1_time_ff;
         s2_rest_ff   <= s1_rest_ff;

         s3_step_ff   <= s3_step_in;
         s3_time_ff   <= s2_time_ff;
         s3_rest_ff   <= s2_rest_ff;

         s4_phase_ff  <= s4_phase_in;
         s4_rest_ff   <= s3_rest_ff;

         s5_idx_ff    <= s5_idx_in;
         s5_neg_ff    <= s5_neg_in;
         s5_rest_ff   <= s4_rest_ff;

         s6_sine_ff   <= s6_sine_in;
         s6_rest_ff   <= s5_rest_ff;

         s7_prod_ff   <= s7_prod_in;
         s7_rest_ff   <= s6_rest_ff;

         s8_mix_ff    <= s8_mix_in;
         s8_rest_ff   <= s7_rest_ff;

         s9_left_ff   <= s9_left_in;
         s9_right_ff  <= s9_right_in;
         s9_rest_ff   <= s8_rest_ff;

         rsp_left_ff  <= rsp_left_in;
         rsp_right_ff <= rsp_right_in;
      end
   end

   assign rsp_valid        = valid_ff[hsts_pkg::STAGES-1];
   assign rsp_left_sample  = rsp_left_ff;
   assign rsp_right_sample = rsp_right_ff;

endmodule

### hdl/hsts_checker.sv
// Port-level checks of the harmonic sine tone synthesizer and their bind.
module hsts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_left_sample,
   input logic [15:0] rsp_right_sample
);

   // a stalled result beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // a stalled result beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_left_sample) && $stable(rsp_right_sample))
      else $error("rsp payload changed while stalled");

   // pipeline is empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a held result must hold back the input side
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("req taken while result pipeline is frozen");

endmodule

bind harmonic_sine_tone_synth_unit hsts_checker u_hsts_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_left_sample  (rsp_left_sample),
   .rsp_right_sample (rsp_right_sample)
);
